[rtl/pwfd_pkg.sv]
// Shared types and constants for the pulse width frame decoder.
// No dependencies; imported by the decoder, the top level and the checker.
package pwfd_pkg;

  localparam int CNT_W       = 8;
  localparam int LEAD_W      = 24;
  localparam int RESP_W      = 64;
  localparam int TIME_W      = 15;
  localparam int NUM_BYTES   = 8;
  localparam int BCNT_W      = 4;

  // Frame lengths, in pulses, that select a result
  localparam logic [CNT_W-1:0] SHORT_FRAME  = 8'd9;
  localparam logic [CNT_W-1:0] MEDIUM_FRAME = 8'd25;
  localparam logic [CNT_W-1:0] LONG_FRAME   = 8'd90;
  localparam logic [CNT_W-1:0] CNT_MAX      = 8'd255;

  // Echoed command pulses ahead of the response field
  localparam int ECHO_PULSES = 25;

  // Byte counts reported for each frame kind
  localparam logic [BCNT_W-1:0] BYTES_NONE   = 4'd0;
  localparam logic [BCNT_W-1:0] BYTES_SHORT  = 4'd1;
  localparam logic [BCNT_W-1:0] BYTES_MEDIUM = 4'd3;
  localparam logic [BCNT_W-1:0] BYTES_LONG   = 4'd8;

  typedef logic [NUM_BYTES-1:0][7:0] byte_vec_t;

  typedef struct packed {
    logic [BCNT_W-1:0] byte_count;
    byte_vec_t         data;   // data[0] is the first byte
  } result_t;

endpackage

[rtl/pwfd_decode.sv]
// Frame result selection: picks byte count and bytes from the frame length.
// Depends on pwfd_pkg.
module pwfd_decode (
  input  logic [pwfd_pkg::CNT_W-1:0]  pulse_count,
  input  logic [pwfd_pkg::LEAD_W-1:0] leading_bits,
  input  logic [pwfd_pkg::RESP_W-1:0] response_bits,
  output pwfd_pkg::result_t           result
);
  import pwfd_pkg::*;

  // Unused bytes stay zero
  always_comb begin
    result = '0;
    if (pulse_count == SHORT_FRAME) begin
      result.byte_count = BYTES_SHORT;
      result.data[0]    = leading_bits[23:16];
    end else if (pulse_count == MEDIUM_FRAME) begin
      result.byte_count = BYTES_MEDIUM;
      result.data[0]    = leading_bits[23:16];
      result.data[1]    = leading_bits[15:8];
      result.data[2]    = leading_bits[7:0];
    end else if (pulse_count >= LONG_FRAME) begin
      result.byte_count = BYTES_LONG;
      for (int k = 0; k < NUM_BYTES; k++) begin
        result.data[k] = response_bits[RESP_W-1-8*k -: 8];
      end
    end
  end

endmodule

[rtl/pulse_width_frame_decoder.sv]
// Top level of the pulse width frame decoder: input register, bit store,
// frame counter and result register. Depends on pwfd_pkg and pwfd_decode.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | low_time, high_time, frame_end
//   out     | output    | out_valid/out_stall| byte_count, byte0..byte7
//
// One pulse per cycle sustained while no frame end waits on a stalled result;
// a pulse is taken into the input register, and as it leaves that register it
// updates the bit store or, on a frame end, clears it and loads the result
// register, from which the result is offered.
// Reset clears the pulse count, both bit stores and all valid flags.
// A frame end waits in the input register only while a result is stalled;
// other pulses keep flowing under an output stall.
module pulse_width_frame_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pwfd_pkg::TIME_W-1:0] in_low_time,
  input  logic [pwfd_pkg::TIME_W-1:0] in_high_time,
  input  logic                        in_frame_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pwfd_pkg::BCNT_W-1:0] out_byte_count,
  output logic [7:0]                  out_byte0,
  output logic [7:0]                  out_byte1,
  output logic [7:0]                  out_byte2,
  output logic [7:0]                  out_byte3,
  output logic [7:0]                  out_byte4,
  output logic [7:0]                  out_byte5,
  output logic [7:0]                  out_byte6,
  output logic [7:0]                  out_byte7
);
  import pwfd_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [TIME_W-1:0] s1_low_r, s1_high_r;
  logic              s1_end_r;
  logic              in_accept, s1_advance;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_upd;
  logic [LEAD_W-1:0] lead_r, lead_nxt, lead_upd;
  logic [RESP_W-1:0] resp_r, resp_nxt, resp_upd;
  logic              one_bit;

  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r, dec_res;

  // Flow control: only a frame end needs room in the result register
  assign s1_advance = s1_valid_r && (!s1_end_r || !out_valid_r || !out_stall);
  assign in_stall   = s1_valid_r && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_accept) begin
      s1_low_r  <= in_low_time;
      s1_high_r <= in_high_time;
      s1_end_r  <= in_frame_end;
    end
  end

  // Bit store update for the pulse in the input register
  assign one_bit = s1_low_r < s1_high_r;

  always_comb begin
    lead_upd = lead_r;
    resp_upd = resp_r;
    for (int i = 0; i < LEAD_W; i++) begin
      if (one_bit && cnt_r == CNT_W'(i)) begin
        lead_upd[LEAD_W-1-i] = 1'b1;
      end
    end
    for (int j = 0; j < RESP_W; j++) begin
      if (one_bit && cnt_r == CNT_W'(ECHO_PULSES + RESP_W - 1 - j)) begin
        resp_upd[j] = 1'b1;
      end
    end
    cnt_upd = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  end

  // Frame end returns the pulse count and both bit stores to zero
  always_comb begin
    cnt_nxt  = cnt_r;
    lead_nxt = lead_r;
    resp_nxt = resp_r;
    if (s1_advance) begin
      if (s1_end_r) begin
        cnt_nxt  = '0;
        lead_nxt = '0;
        resp_nxt = '0;
      end else begin
        cnt_nxt  = cnt_upd;
        lead_nxt = lead_upd;
        resp_nxt = resp_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      lead_r <= '0;
      resp_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      lead_r <= lead_nxt;
      resp_r <= resp_nxt;
    end
  end

  pwfd_decode u_decode (
    .pulse_count   (cnt_upd),
    .leading_bits  (lead_upd),
    .response_bits (resp_upd),
    .result        (dec_res)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_advance && s1_end_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (s1_advance && s1_end_r) begin
      out_res_r <= dec_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte_count = out_res_r.byte_count;
  assign out_byte0      = out_res_r.data[0];
  assign out_byte1      = out_res_r.data[1];
  assign out_byte2      = out_res_r.data[2];
  assign out_byte3      = out_res_r.data[3];
  assign out_byte4      = out_res_r.data[4];
  assign out_byte5      = out_res_r.data[5];
  assign out_byte6      = out_res_r.data[6];
  assign out_byte7      = out_res_r.data[7];

endmodule

[rtl/pwfd_checker.sv]
// Port-level checks for the pulse width frame decoder, bound to the top.
// Depends on pwfd_pkg and pulse_width_frame_decoder.
module pwfd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [pwfd_pkg::BCNT_W-1:0] out_byte_count,
  input logic [7:0]                  out_byte0,
  input logic [7:0]                  out_byte1,
  input logic [7:0]                  out_byte2,
  input logic [7:0]                  out_byte3,
  input logic [7:0]                  out_byte4,
  input logic [7:0]                  out_byte5,
  input logic [7:0]                  out_byte6,
  input logic [7:0]                  out_byte7
);
  import pwfd_pkg::*;

  // A stalled result holds (byte count, byte0 and byte7 are checked)
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_count) &&
      $stable(out_byte0) && $stable(out_byte7))
    else $error("stalled result changed");

  // Only the defined frame kinds are reported
  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count == BYTES_NONE || out_byte_count == BYTES_SHORT ||
      out_byte_count == BYTES_MEDIUM || out_byte_count == BYTES_LONG))
    else $error("illegal byte count");

  // Bytes past the count are zero
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_count == BYTES_SHORT |->
      (out_byte1 | out_byte2 | out_byte3 | out_byte4 | out_byte5 |
       out_byte6 | out_byte7) == 8'd0)
    else $error("short frame has extra bytes");

  a_medium_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_count == BYTES_MEDIUM |->
      (out_byte3 | out_byte4 | out_byte5 | out_byte6 | out_byte7) == 8'd0)
    else $error("medium frame has extra bytes");

  // The input side stalls only while a result is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

endmodule

bind pulse_width_frame_decoder pwfd_checker u_pwfd_checker (.*);
